[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, idle during reset
`define SOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold
`define SOC_NEVER(lbl, cond, msg) \
  `SOC_ASSERT(lbl, !(cond), msg)

`endif

[design/soc_pkg.sv]
`default_nettype none
package soc_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int PAT_AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int COUNT_W = 32;
  localparam int KEY_W = 32;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_PATTERN = 2'd1;
  localparam logic [1:0] REQ_TEXT    = 2'd2;
  localparam logic [1:0] REQ_FINISH  = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [PAT_AW-1:0] pat_addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic      pat_we;
    pat_addr_t pat_waddr;
    key_t      pat_wdata;
    pat_addr_t pat_raddr;
    logic      cnt_we;
    len_t      cnt_waddr;
    count_t    cnt_wdata;
    len_t      cnt_raddr;
    logic      cnt_clear_all;
    logic      cnt_invalidate;
    len_t      cnt_inv_addr;
  } soc_mem_ctrl_t;

endpackage
`default_nettype wire

[design/soc_step_unit.sv]
`default_nettype none
module soc_step_unit (
  input  wire soc_pkg::count_t cur_count,
  input  wire soc_pkg::count_t low_count,
  input  wire soc_pkg::key_t   pat_key,
  input  wire soc_pkg::key_t   text_key,
  output logic                 hit,
  output soc_pkg::count_t      new_count,
  output logic                 sat
);
  import soc_pkg::*;

  logic [COUNT_W:0] sum;

  always_comb begin
    hit = (pat_key == text_key);
    sum = {1'b0, cur_count} + {1'b0, low_count};
    sat = (sum >= {1'b0, COUNT_MAX});
    new_count = sat ? COUNT_MAX : sum[COUNT_W-1:0];
  end
endmodule
`default_nettype wire

[design/soc_store.sv]
`default_nettype none
module soc_store (
  input  wire                         clk,
  input  wire                         rst,
  input  wire soc_pkg::soc_mem_ctrl_t ctrl,
  output soc_pkg::key_t               pat_rdata,
  output soc_pkg::count_t             cnt_rdata
);
  import soc_pkg::*;

  key_t   pat_mem [PATTERN_MAX];
  count_t cnt_mem [PATTERN_MAX+1];
  logic [PATTERN_MAX:0] cnt_valid;
  count_t cnt_raw;
  logic   rd_valid;
  logic   rd_zero;

  always_ff @(posedge clk) begin
    if (ctrl.pat_we) begin
      pat_mem[ctrl.pat_waddr] <= ctrl.pat_wdata;
    end
    pat_rdata <= pat_mem[ctrl.pat_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.cnt_we) begin
      cnt_mem[ctrl.cnt_waddr] <= ctrl.cnt_wdata;
    end
    cnt_raw <= cnt_mem[ctrl.cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.cnt_clear_all) begin
      cnt_valid <= '0;
    end else if (ctrl.cnt_invalidate) begin
      cnt_valid[ctrl.cnt_inv_addr] <= 1'b0;
    end else if (ctrl.cnt_we) begin
      cnt_valid[ctrl.cnt_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= cnt_valid[ctrl.cnt_raddr];
    rd_zero  <= (ctrl.cnt_raddr == '0);
  end

  assign cnt_rdata = rd_valid ? cnt_raw : {{(COUNT_W-1){1'b0}}, rd_zero};
endmodule
`default_nettype wire

[design/subsequence_occurrence_counter.sv]
// Subsequence occurrence counter.
// Input channel: in_valid / in_stall with req_type and element_value.
//   start clears the job, pattern appends a key (up to the store depth),
//   text updates each prefix count whose key matches, finish requests a result.
// Output channel: out_valid / out_stall with match_count, count_saturated
//   and pattern_overflow; one result per finish request.
// Start and pattern requests leave the block idle. A text request steps
// through states TOP, LOAD and UPD for a non-empty pattern: one shared
// adder and key compare walks the prefix counts from the longest prefix
// down, one entry per cycle, through the count memory read port.
// A finish request passes through states FIN and OUT before its result
// is registered; further requests wait until the block is idle again.
// The result waits in an output register while out_stall is high; start,
// pattern and text requests still enter meanwhile, a further finish
// request is held off until the waiting result is taken.
// Reset (rst, synchronous) acts as a fresh job: empty pattern, count 1,
// flags clear, no result pending.
`default_nettype none
module subsequence_occurrence_counter (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         req_type,
  input  wire soc_pkg::key_t element_value,
  output logic               out_valid,
  input  wire                out_stall,
  output soc_pkg::count_t    match_count,
  output logic               count_saturated,
  output logic               pattern_overflow
);
  import soc_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TOP  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state;
  logic [2:0]    state_next;
  len_t          len;
  len_t          k;
  key_t          text_key;
  count_t        cur;
  logic          sat_flag;
  logic          ovf_flag;
  logic          accept;
  soc_mem_ctrl_t ctrl;
  key_t          pat_rdata;
  count_t        cnt_rdata;
  logic          hit;
  count_t        new_count;
  logic          sat;
  len_t          k_m1;
  len_t          k_m2;
  len_t          len_p1;

  assign in_stall = (state != S_IDLE) || (out_valid && (req_type == REQ_FINISH));
  assign accept   = in_valid && !in_stall;
  assign k_m1     = k - len_t'(1);
  assign k_m2     = k - len_t'(2);
  assign len_p1   = len + len_t'(1);

  soc_store u_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .pat_rdata (pat_rdata),
    .cnt_rdata (cnt_rdata)
  );

  soc_step_unit u_step (
    .cur_count (cur),
    .low_count (cnt_rdata),
    .pat_key   (pat_rdata),
    .text_key  (text_key),
    .hit       (hit),
    .new_count (new_count),
    .sat       (sat)
  );

  always_comb begin
    ctrl = '0;
    ctrl.pat_waddr = len[PAT_AW-1:0];
    ctrl.pat_wdata = element_value;
    ctrl.cnt_waddr = k;
    ctrl.cnt_wdata = new_count;
    ctrl.cnt_inv_addr = len_p1;
    case (state)
      S_IDLE: begin
        if (accept && (req_type == REQ_START)) begin
          ctrl.cnt_clear_all = 1'b1;
        end
        if (accept && (req_type == REQ_PATTERN) && (len < len_t'(PATTERN_MAX))) begin
          ctrl.pat_we = 1'b1;
          ctrl.cnt_invalidate = 1'b1;
        end
      end
      S_TOP: ctrl.cnt_raddr = k;
      S_LOAD: begin
        ctrl.cnt_raddr = k_m1;
        ctrl.pat_raddr = k_m1[PAT_AW-1:0];
      end
      S_UPD: begin
        ctrl.cnt_raddr = k_m2;
        ctrl.pat_raddr = k_m2[PAT_AW-1:0];
        ctrl.cnt_we = hit;
      end
      S_FIN: ctrl.cnt_raddr = len;
      default: ctrl.cnt_raddr = len;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (req_type == REQ_TEXT) && (len != '0)) begin
          state_next = S_TOP;
        end else if (accept && (req_type == REQ_FINISH)) begin
          state_next = S_FIN;
        end
      end
      S_TOP:  state_next = S_LOAD;
      S_LOAD: state_next = S_UPD;
      S_UPD:  state_next = (k == len_t'(1)) ? S_IDLE : S_UPD;
      S_FIN:  state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len <= '0;
      sat_flag <= 1'b0;
      ovf_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (req_type == REQ_START)) begin
        len <= '0;
        sat_flag <= 1'b0;
        ovf_flag <= 1'b0;
      end
      if (accept && (req_type == REQ_PATTERN)) begin
        if (len < len_t'(PATTERN_MAX)) begin
          len <= len_p1;
        end else begin
          ovf_flag <= 1'b1;
        end
      end
      if ((state == S_UPD) && hit && sat) begin
        sat_flag <= 1'b1;
      end
      if (state == S_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      text_key <= element_value;
    end
    case (state)
      S_IDLE: k <= len;
      S_LOAD: cur <= cnt_rdata;
      S_UPD: begin
        cur <= cnt_rdata;
        k <= k_m1;
      end
      default: ;
    endcase
    if (state == S_OUT) begin
      match_count <= cnt_rdata;
      count_saturated <= sat_flag;
      pattern_overflow <= ovf_flag;
    end
  end

  `SOC_ASSERT(a_busy_stalls, (state != S_IDLE) |-> in_stall, "request accepted while busy")
  `SOC_NEVER(a_len_range, len > len_t'(PATTERN_MAX), "pattern length beyond store depth")
  `SOC_NEVER(a_upd_k_zero, (state == S_UPD) && (k == '0), "update walk reached prefix zero")
  `SOC_ASSERT(a_out_from_fin, $rose(out_valid) |-> ($past(state) == S_OUT), "result not from finish")
endmodule
`default_nettype wire

[dv/subsequence_occurrence_counter_tb.sv]
`timescale 1ns / 1ps
module subsequence_occurrence_counter_tb;
  import soc_pkg::*;

  localparam int REQUEST_TARGET = 1600;
  localparam int CYCLE_LIMIT = 500000;

  class occurrence_scoreboard;
    typedef struct {
      count_t total;
      logic   sat;
      logic   ovf;
    } tally_t;

    key_t        pattern_keys[PATTERN_MAX];
    int unsigned pattern_len;
    count_t      prefix_tally[PATTERN_MAX+1];
    logic        sat_seen;
    logic        ovf_seen;
    tally_t      tally_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_job();
    endfunction

    function void clear_job();
      pattern_len = 0;
      foreach (prefix_tally[i]) prefix_tally[i] = '0;
      prefix_tally[0] = 1;
      sat_seen = 1'b0;
      ovf_seen = 1'b0;
    endfunction

    function void note_request(logic [1:0] req, key_t key);
      logic [COUNT_W:0] sum;
      tally_t t;
      case (req)
        REQ_START: begin
          clear_job();
        end
        REQ_PATTERN: begin
          if (pattern_len >= PATTERN_MAX) begin
            ovf_seen = 1'b1;
          end else begin
            pattern_keys[pattern_len] = key;
            pattern_len++;
            prefix_tally[pattern_len] = '0;
          end
        end
        REQ_TEXT: begin
          // walk from the longest prefix down so each entry uses old values
          for (int k = pattern_len; k >= 1; k--) begin
            if (pattern_keys[k-1] == key) begin
              sum = {1'b0, prefix_tally[k]} + {1'b0, prefix_tally[k-1]};
              if (sum >= {1'b0, COUNT_MAX}) begin
                prefix_tally[k] = COUNT_MAX;
                sat_seen = 1'b1;
              end else begin
                prefix_tally[k] = sum[COUNT_W-1:0];
              end
            end
          end
        end
        default: begin
          t.total = prefix_tally[pattern_len];
          t.sat = sat_seen;
          t.ovf = ovf_seen;
          tally_q.push_back(t);
        end
      endcase
    endfunction

    function void check_result(count_t total, logic sat, logic ovf);
      tally_t t;
      if (tally_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count %0d sat %0b ovf %0b",
                 $time, total, sat, ovf);
        errors++;
        return;
      end
      t = tally_q.pop_front();
      if (total !== t.total) begin
        $display("%0t: match_count mismatch, expected %0d, actual %0d", $time, t.total, total);
        errors++;
      end
      if (sat !== t.sat) begin
        $display("%0t: count_saturated mismatch, expected %0b, actual %0b", $time, t.sat, sat);
        errors++;
      end
      if (ovf !== t.ovf) begin
        $display("%0t: pattern_overflow mismatch, expected %0b, actual %0b",
                 $time, t.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return tally_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_type = REQ_START;
  key_t       element_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  count_t     match_count;
  logic       count_saturated;
  logic       pattern_overflow;

  occurrence_scoreboard sb;
  int burst_left = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int stall_hold = 0;

  subsequence_occurrence_counter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .element_value(element_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .match_count(match_count),
    .count_saturated(count_saturated),
    .pattern_overflow(pattern_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("subsequence_occurrence_counter_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (cycle_count % 300 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= (cycle_count % 7 < 3);
      end
      default: begin
        if (stall_hold == 0 && $urandom_range(0, 5) == 0) begin
          stall_hold = $urandom_range(1, 12);
        end
        out_stall <= (stall_hold != 0);
        if (stall_hold != 0) stall_hold--;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(match_count, count_saturated, pattern_overflow);
    end
  end

  task automatic send_request(input logic [1:0] req, input key_t key);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= req;
    element_value <= key;
    do @(posedge clk); while (in_stall);
    sb.note_request(req, key);
    burst_left--;
    items_sent++;
  endtask

  // hold off requests until every result has been taken
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_job();
    int kind;
    int plen;
    int tlen;
    int nsym;
    int r;
    key_t alpha[4];
    foreach (alpha[i]) alpha[i] = pick_key();
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      // same key throughout a full pattern can drive the counts to saturation
      send_request(REQ_START, $urandom);
      repeat (PATTERN_MAX) send_request(REQ_PATTERN, alpha[0]);
      tlen = $urandom_range(30, 50);
      repeat (tlen) send_request(REQ_TEXT, alpha[0]);
      send_request(REQ_FINISH, $urandom);
    end else if (kind < 10) begin
      tlen = $urandom_range(1, 8);
      repeat (tlen) send_request(2'($urandom_range(0, 3)), $urandom);
    end else begin
      if ($urandom_range(0, 9) != 0) send_request(REQ_START, $urandom);
      r = $urandom_range(0, 9);
      plen = (r == 0) ? $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 3) :
             (r < 3)  ? $urandom_range(6, PATTERN_MAX) : $urandom_range(0, 4);
      nsym = $urandom_range(1, 4);
      repeat (plen) send_request(REQ_PATTERN, alpha[$urandom_range(0, nsym - 1)]);
      tlen = $urandom_range(0, 14);
      repeat (tlen) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_request(REQ_PATTERN, alpha[$urandom_range(0, nsym - 1)]);
        end else if (r == 1) begin
          send_request(REQ_FINISH, $urandom);
        end else if (r == 2) begin
          send_request(REQ_TEXT, $urandom);
        end else begin
          send_request(REQ_TEXT, alpha[$urandom_range(0, nsym - 1)]);
        end
      end
      if ($urandom_range(0, 19) != 0) send_request(REQ_FINISH, $urandom);
    end
  endtask

  initial begin
    int job_count;
    sb = new();
    job_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(REQ_FINISH, 32'h0000_0000);
    send_request(REQ_TEXT, 32'h7FFF_FFFF);
    send_request(REQ_PATTERN, 32'h8000_0000);
    send_request(REQ_TEXT, 32'h8000_0000);
    send_request(REQ_FINISH, 32'hFFFF_FFFF);
    send_request(REQ_PATTERN, 32'h7FFF_FFFF);
    send_request(REQ_FINISH, 32'h0000_0000);
    send_request(REQ_TEXT, 32'h7FFF_FFFF);
    send_request(REQ_FINISH, 32'h0000_0000);
    send_request(REQ_FINISH, 32'h8000_0000);
    send_request(REQ_START, 32'hFFFF_FFFF);
    send_request(REQ_FINISH, 32'h7FFF_FFFF);
    send_request(REQ_PATTERN, 32'h0000_0000);
    send_request(REQ_PATTERN, 32'hFFFF_FFFF);
    send_request(REQ_TEXT, 32'h0000_0000);
    send_request(REQ_TEXT, 32'hFFFF_FFFF);
    send_request(REQ_TEXT, 32'h0000_0000);
    send_request(REQ_TEXT, 32'hFFFF_FFFF);
    send_request(REQ_FINISH, 32'h0000_0000);
    send_request(REQ_TEXT, 32'h1234_5678);
    send_request(REQ_PATTERN, 32'h0000_0000);
    send_request(REQ_TEXT, 32'h0000_0000);
    send_request(REQ_FINISH, 32'h0000_0000);
    send_request(REQ_START, 32'h0000_0000);
    send_request(REQ_FINISH, 32'h0000_0000);
    drain();

    while (items_sent < REQUEST_TARGET) begin
      run_job();
      job_count++;
      if (job_count % 25 == 0) drain();
    end

    drain();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("subsequence_occurrence_counter_tb: PASS");
    end else begin
      $display("subsequence_occurrence_counter_tb: FAIL");
    end
    $finish;
  end
endmodule
